/* rtl/core/blp_pkg.sv */
package blp_pkg;

  // Occupancy of the setup queue, seen by both of its neighbours
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  localparam int unsigned QueueDepth = 2;

endpackage

/* rtl/core/blp_front.sv */
module blp_front #(
  parameter int unsigned COORD_BITS = 6,
  parameter int unsigned SETUP_W    = 8 * COORD_BITS + 7
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  blp_pkg::q_stat_t             q_stat,
  output logic                         q_push,
  output logic [SETUP_W-1:0]           q_data
);

  localparam int unsigned C = COORD_BITS;

  logic               valid;
  logic [SETUP_W-1:0] setup;
  logic               load;

  logic [C:0]   dx, dy;
  logic [C-1:0] ax, ay;
  logic [C-1:0] stepx, stepy;
  logic         x_major;
  logic [C-1:0] major, minor;
  logic [C+1:0] err0, inc_a, inc_b;
  logic [C:0]   diff;

  assign q_push   = valid && !q_stat.full;
  assign in_stall = valid && !q_push;
  assign load     = in_valid && !in_stall;
  assign q_data   = setup;

  always_comb begin
    dx = {end_x[C-1], end_x} - {start_x[C-1], start_x};
    dy = {end_y[C-1], end_y} - {start_y[C-1], start_y};
    ax = dx[C] ? C'(-dx) : dx[C-1:0];
    ay = dy[C] ? C'(-dy) : dy[C-1:0];
    // step along an axis by the sign of its delta
    if (dx == '0) begin
      stepx = '0;
    end else if (dx[C]) begin
      stepx = '1;
    end else begin
      stepx = C'(1);
    end
    if (dy == '0) begin
      stepy = '0;
    end else if (dy[C]) begin
      stepy = '1;
    end else begin
      stepy = C'(1);
    end
    x_major = ax > ay;
    major   = x_major ? ax : ay;
    minor   = x_major ? ay : ax;
    inc_a   = {1'b0, minor, 1'b0};
    err0    = inc_a - {2'b00, major};
    diff    = {1'b0, minor} - {1'b0, major};
    inc_b   = {diff, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (q_push) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      setup <= {start_x, start_y, stepx, stepy, x_major, major, err0, inc_a, inc_b};
    end
  end

endmodule

/* rtl/core/blp_queue.sv */
module blp_queue #(
  parameter int unsigned WIDTH = 55
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [WIDTH-1:0]  push_data,
  input  logic              pop,
  output logic [WIDTH-1:0]  head,
  output blp_pkg::q_stat_t  stat
);

  localparam int unsigned PTR_W = $clog2(blp_pkg::QueueDepth);
  localparam int unsigned CNT_W = $clog2(blp_pkg::QueueDepth + 1);

  logic [WIDTH-1:0] entries [blp_pkg::QueueDepth];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign stat.empty = count == '0;
  assign stat.full  = count == CNT_W'(blp_pkg::QueueDepth);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

/* rtl/core/blp_back.sv */
module blp_back #(
  parameter int unsigned COORD_BITS = 6,
  parameter int unsigned SETUP_W    = 8 * COORD_BITS + 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  blp_pkg::q_stat_t              q_stat,
  input  logic [SETUP_W-1:0]            q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS-1:0]  point_x,
  output logic signed [COORD_BITS-1:0]  point_y,
  output logic                          last_point
);

  localparam int unsigned C = COORD_BITS;

  logic         busy;
  logic         adv;
  logic [C-1:0] px, py, stepx, stepy, rem;
  logic         x_major;
  logic [C+1:0] err, inc_a, inc_b;
  logic         diag;

  logic [C-1:0] h_x0, h_y0, h_sx, h_sy, h_major;
  logic         h_xmaj;
  logic [C+1:0] h_err0, h_inc_a, h_inc_b;

  assign {h_x0, h_y0, h_sx, h_sy, h_xmaj, h_major, h_err0, h_inc_a, h_inc_b} = q_head;

  assign q_pop = !busy && !q_stat.empty;
  assign adv   = busy && (!out_valid || !out_stall);
  // step both axes only while the error is positive
  assign diag  = !err[C+1] && (err != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
      end else if (adv && rem == '0) begin
        busy <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      px      <= h_x0;
      py      <= h_y0;
      stepx   <= h_sx;
      stepy   <= h_sy;
      x_major <= h_xmaj;
      rem     <= h_major;
      err     <= h_err0;
      inc_a   <= h_inc_a;
      inc_b   <= h_inc_b;
    end else if (adv) begin
      rem <= rem - C'(1);
      if (diag) begin
        px  <= px + stepx;
        py  <= py + stepy;
        err <= err + inc_b;
      end else begin
        if (x_major) begin
          px <= px + stepx;
        end else begin
          py <= py + stepy;
        end
        err <= err + inc_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      point_x    <= px;
      point_y    <= py;
      last_point <= rem == '0;
    end
  end

endmodule

/* rtl/core/bresenham_line_points_core.sv */
// A request passes the front setup register, the setup queue, the stepper and the output register.
// Throughput: one point per cycle within a line while out_stall is low; a line holds up to
// 2**COORD_BITS points and is drawn by the single point stepper.
// A two-entry setup queue lets new requests be accepted while a line is being drawn.
// Reset (synchronous, active high) empties the front register, the queue and the stepper.
module bresenham_line_points_core #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y,
  output logic                         last_point
);

  localparam int unsigned SETUP_W = 8 * COORD_BITS + 7;

  blp_pkg::q_stat_t   q_stat;
  logic               q_push, q_pop;
  logic [SETUP_W-1:0] q_in, q_head;

  blp_front #(
    .COORD_BITS (COORD_BITS),
    .SETUP_W    (SETUP_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .start_x  (start_x),
    .start_y  (start_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  blp_queue #(
    .WIDTH (SETUP_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  blp_back #(
    .COORD_BITS (COORD_BITS),
    .SETUP_W    (SETUP_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_stat     (q_stat),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .point_x    (point_x),
    .point_y    (point_y),
    .last_point (last_point)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int CW = 6;
  localparam int COORD_LO = -(1 << (CW - 1));
  localparam int COORD_HI = (1 << (CW - 1)) - 1;
  localparam int RANDOM_LINES = 260;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 50;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } line_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } raster_point_t;

  class point_ledger;
    raster_point_t expected_q[$];
    int unsigned mismatches;
    int unsigned checked;

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%0t mismatch: %s", $time, what);
    endtask

    // Walk the line with the integer error term and queue every point it covers.
    function void note_line(line_t l);
      int dx, dy, sx, sy, ax, ay, major, minor, err, px, py;
      bit x_major;
      raster_point_t pt;
      dx = int'(l.x1) - int'(l.x0);
      dy = int'(l.y1) - int'(l.y0);
      sx = (dx > 0) ? 1 : (dx < 0) ? -1 : 0;
      sy = (dy > 0) ? 1 : (dy < 0) ? -1 : 0;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      // a tie goes to y
      x_major = ax > ay;
      major = x_major ? ax : ay;
      minor = x_major ? ay : ax;
      err = 2 * minor - major;
      px = l.x0;
      py = l.y0;
      for (int i = 0; i <= major; i++) begin
        pt.x = px[CW-1:0];
        pt.y = py[CW-1:0];
        pt.last = (i == major);
        expected_q.push_back(pt);
        if (err <= 0) begin
          if (x_major) px += sx;
          else py += sy;
          err += 2 * minor;
        end else begin
          px += sx;
          py += sy;
          err += 2 * (minor - major);
        end
      end
    endfunction

    task check_point(coord_t x, coord_t y, logic last);
      raster_point_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected point (%0d,%0d) last=%b", x, y, last));
        return;
      end
      want = expected_q.pop_front();
      if (x !== want.x)
        report_mismatch($sformatf("point_x %0d, want %0d", x, want.x));
      if (y !== want.y)
        report_mismatch($sformatf("point_y %0d, want %0d", y, want.y));
      if (last !== want.last)
        report_mismatch($sformatf("last_point %b, want %b at (%0d,%0d)",
                                  last, want.last, want.x, want.y));
    endtask
  endclass

  logic   clk = 1'b0;
  logic   rst;
  logic   in_valid;
  logic   in_stall;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  logic   out_valid;
  logic   out_stall;
  coord_t point_x;
  coord_t point_y;
  logic   last_point;

  point_ledger ledger = new();
  int unsigned lines_sent;
  bit hold_off_req;

  bresenham_line_points_core #(
    .COORD_BITS(CW)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .start_x(start_x),
    .start_y(start_y),
    .end_x(end_x),
    .end_y(end_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .point_x(point_x),
    .point_y(point_y),
    .last_point(last_point)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0)
      ledger.check_point(point_x, point_y, last_point);
  end

  // Hold the request until the block takes it.
  task send_line(line_t l);
    in_valid <= 1'b1;
    start_x <= l.x0;
    start_y <= l.y0;
    end_x <= l.x1;
    end_y <= l.y1;
    do @(posedge clk); while (in_stall !== 1'b0);
    ledger.note_line(l);
    lines_sent++;
  endtask

  task sender_gap(int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task wait_drained();
    while (ledger.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic coord_t near_coord(coord_t base);
    int v;
    v = int'(base) + int'($urandom_range(0, 14)) - 7;
    if (v < COORD_LO) v = COORD_LO;
    if (v > COORD_HI) v = COORD_HI;
    return v[CW-1:0];
  endfunction

  // Mostly short lines, with full-range ones mixed in.
  function automatic line_t pick_line();
    line_t l;
    l.x0 = coord_t'($urandom);
    l.y0 = coord_t'($urandom);
    if ($urandom_range(0, 9) < 7) begin
      l.x1 = near_coord(l.x0);
      l.y1 = near_coord(l.y0);
    end else begin
      l.x1 = coord_t'($urandom);
      l.y1 = coord_t'($urandom);
    end
    return l;
  endfunction

  // Output stall pattern: switch modes now and then, long hold-off on demand.
  initial begin
    int mode;
    int span;
    int held;
    out_stall <= 1'b0;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        held = 0;
        while (held < HOLD_OFF_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
          held++;
        end
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 120);
      repeat (span) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
        @(posedge clk);
        if (hold_off_req) break;
      end
    end
  end

  initial begin
    line_t directed_lines[16];
    line_t l;
    int unsigned random_sent;
    int burst;
    bit held_off;
    bit drained;

    directed_lines = '{
      '{0, 0, 0, 0},
      '{-32, -32, -32, -32},
      '{31, 31, 31, 31},
      '{-32, -32, 31, 31},
      '{31, -32, -32, 31},
      '{-32, 0, 31, 0},
      '{5, 31, 5, -32},
      '{0, 0, 7, 3},
      '{0, 0, -3, -7},
      '{-10, 4, 10, -4},
      '{2, 2, 6, 5},
      '{2, 2, 5, 6},
      '{-32, 31, 31, -32},
      '{0, -32, 31, 31},
      '{1, 0, 0, 1},
      '{31, 0, -32, -1}
    };
    random_sent = 0;
    held_off = 1'b0;
    drained = 1'b0;
    lines_sent = 0;
    hold_off_req = 1'b0;

    rst <= 1'b1;
    in_valid <= 1'b0;
    start_x <= '0;
    start_y <= '0;
    end_x <= '0;
    end_y <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_lines[i]) begin
      send_line(directed_lines[i]);
      sender_gap($urandom_range(0, 2));
    end

    while (random_sent < RANDOM_LINES) begin
      if (!held_off && random_sent >= 90) begin
        // Stall the output and keep offering lines so the input backs up.
        hold_off_req = 1'b1;
        repeat (12) begin
          send_line(pick_line());
          random_sent++;
        end
        held_off = 1'b1;
      end
      if (!drained && random_sent >= 180) begin
        sender_gap(1);
        wait_drained();
        drained = 1'b1;
      end
      burst = $urandom_range(1, 10);
      repeat (burst) begin
        l = pick_line();
        send_line(l);
        random_sent++;
      end
      sender_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
    end

    sender_gap(1);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d lines sent (%0d directed, %0d random), %0d points checked",
             lines_sent, $size(directed_lines), random_sent, ledger.checked);
    $display("output held off for %0d cycles once, input drained once mid-run",
             HOLD_OFF_CYCLES);
    if (ledger.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", ledger.mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d points outstanding", ledger.expected_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
